[rtl/ppv_pkg.sv]
package ppv_pkg;

  localparam int unsigned SAMPLE_W       = 7;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned PROB_W         = 32;
  localparam int unsigned MAX_SAMPLE_DEF = 64;

  // Fixed-point 1.0 with 31 fraction bits.
  localparam logic [PROB_W-1:0] ONE_FIX = 32'h8000_0000;

  // Quotient bits retired per divider cycle, and divider cycles per update.
  localparam int unsigned DIV_STEP  = 8;
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_CYC   = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INIT,
    ST_RD,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_WR,
    ST_ERD,
    ST_EOUT
  } ppv_state_t;

endpackage

[rtl/polya_probability_vector_unit.sv]
// Channel   | Direction | Handshake        | Payload
// ----------+-----------+------------------+----------------------------------------------
// in_       | input     | in_valid/in_stall | in_lineages
// out_      | output    | out_valid/out_stall | out_mutant_count, out_probability, out_last,
//           |           |                  | out_bad_request
// cfg_      | input     | cfg_valid/cfg_ready | cfg_sample_size
//
// A bad request yields one error word once the output register has room.
// A good request runs (n-k)*(n-k+3)/2 vector updates, each update being read,
// multiply, add, radix-256 division and write back on the single-port vector
// memory, followed by a read and an emit step per output word.
// Reset (rst_n low, synchronous) clears the control state and the sample size
// returns to 2; the vector memory is not cleared, unwritten entries are masked.
// A stall on the output holds the current word; the engine waits for the slot.
module polya_probability_vector_unit #(
  parameter int unsigned MAX_SAMPLE = ppv_pkg::MAX_SAMPLE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppv_pkg::SAMPLE_W-1:0] in_lineages,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppv_pkg::CNT_W-1:0]    out_mutant_count,
  output logic [ppv_pkg::PROB_W-1:0]   out_probability,
  output logic                         out_last,
  output logic                         out_bad_request,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ppv_pkg::SAMPLE_W-1:0] cfg_sample_size
);
  import ppv_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLE);
  localparam int unsigned MUL_W = PROB_W + SAMPLE_W;

  // Working vector, one entry per mutant count.
  logic [PROB_W-1:0] vec_mem [MAX_SAMPLE];
  logic [PROB_W-1:0] rdata_r;

  ppv_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0]  n_cfg_r, n_cfg_nxt;
  logic [SAMPLE_W-1:0]  n_r, n_nxt;
  logic [SAMPLE_W-1:0]  k_r, k_nxt;
  logic [SAMPLE_W-1:0]  nn_r, nn_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic [PROB_W-1:0]    prev_r, prev_nxt;
  logic [MUL_W-1:0]     p0_r, p0_nxt, p1_r, p1_nxt;
  logic [DIV_W-1:0]     div_r, div_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [SAMPLE_W-2:0]  rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cyc_r, cyc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic [PROB_W-1:0]    out_prob_r, out_prob_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_bad_r, out_bad_nxt;

  logic                 wr_en;
  logic [PROB_W-1:0]    wr_data;

  // Combinational helpers.
  logic                 slot_free;
  logic                 req_bad;
  logic [SAMPLE_W-1:0]  j_ext;
  logic [SAMPLE_W-1:0]  span;
  logic [SAMPLE_W-2:0]  den;
  logic [PROB_W-1:0]    cur;
  logic [SAMPLE_W-1:0]  coef;
  logic [SAMPLE_W-2:0]  rem_v;
  logic [SAMPLE_W-1:0]  trial;
  logic [DIV_STEP-1:0]  qdig;
  logic [PROB_W-1:0]    q_sat;

  assign in_stall         = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_mutant_count = out_cnt_r;
  assign out_probability  = out_prob_r;
  assign out_last         = out_last_r;
  assign out_bad_request  = out_bad_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign j_ext     = SAMPLE_W'(j_r);
  assign span      = nn_r - k_r;
  assign den       = (SAMPLE_W-1)'(nn_r - SAMPLE_W'(1));
  // The newest entry of the support has never been written in this run.
  assign cur       = (j_ext == span) ? '0 : rdata_r;
  assign coef      = nn_r - SAMPLE_W'(2) - j_ext;
  assign req_bad   = (n_cfg_r < SAMPLE_W'(2)) || (n_cfg_r > SAMPLE_W'(MAX_SAMPLE)) ||
                     (in_lineages < SAMPLE_W'(2)) || (in_lineages > n_cfg_r);
  assign q_sat     = (quo_r > DIV_W'(ONE_FIX)) ? ONE_FIX : quo_r[PROB_W-1:0];

  // Radix-256 long division: eight restoring steps on a remainder below den.
  always_comb begin
    rem_v = rem_r;
    trial = '0;
    qdig  = '0;
    for (int b = 0; b < DIV_STEP; b++) begin
      trial = {rem_v, div_r[DIV_W-1-b]};
      if (trial >= SAMPLE_W'(den)) begin
        rem_v = (SAMPLE_W-1)'(trial - SAMPLE_W'(den));
        qdig[DIV_STEP-1-b] = 1'b1;
      end else begin
        rem_v = (SAMPLE_W-1)'(trial);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_cfg_nxt     = n_cfg_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    nn_nxt        = nn_r;
    j_nxt         = j_r;
    prev_nxt      = prev_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cyc_nxt       = cyc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_prob_nxt  = out_prob_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    wr_en         = 1'b0;
    wr_data       = q_sat;

    if (cfg_valid && cfg_ready) begin
      n_cfg_nxt = cfg_sample_size;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          k_nxt  = in_lineages;
          n_nxt  = n_cfg_r;
          nn_nxt = in_lineages + SAMPLE_W'(1);
          j_nxt  = '0;
          state_nxt = req_bad ? ST_ERR : ST_INIT;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = '0;
          out_prob_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_INIT: begin
        // Vector starts as [1.0]; with k equal to n no update runs.
        wr_en    = 1'b1;
        wr_data  = ONE_FIX;
        prev_nxt = '0;
        state_nxt = (k_r == n_r) ? ST_ERD : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        p0_nxt   = MUL_W'(prev_r) * MUL_W'(j_ext);
        p1_nxt   = MUL_W'(cur) * MUL_W'(coef);
        prev_nxt = cur;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        div_nxt = DIV_W'(p0_r) + DIV_W'(p1_r) + DIV_W'(den >> 1);
        rem_nxt = '0;
        quo_nxt = '0;
        cyc_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = rem_v;
        quo_nxt = {quo_r[DIV_W-DIV_STEP-1:0], qdig};
        div_nxt = {div_r[DIV_W-DIV_STEP-1:0], DIV_STEP'(0)};
        cyc_nxt = cyc_r + DIV_CNT_W'(1);
        if (cyc_r == DIV_CNT_W'(DIV_CYC - 1)) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        wr_en = 1'b1;
        if (j_ext == span) begin
          j_nxt    = '0;
          prev_nxt = '0;
          if (nn_r == n_r) begin
            state_nxt = ST_ERD;
          end else begin
            nn_nxt    = nn_r + SAMPLE_W'(1);
            state_nxt = ST_RD;
          end
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_ERD: begin
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = CNT_W'(j_ext + SAMPLE_W'(1));
          // Entries past the final support were never written and read as zero.
          out_prob_nxt  = (j_ext > (n_r - k_r)) ? '0 : rdata_r;
          out_last_nxt  = (j_ext == n_r - SAMPLE_W'(2));
          out_bad_nxt   = 1'b0;
          if (j_ext == n_r - SAMPLE_W'(2)) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + AW'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Single-port vector memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vec_mem[j_r] <= wr_data;
    end
    rdata_r <= vec_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_cfg_r     <= SAMPLE_W'(2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_cfg_r     <= n_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    nn_r       <= nn_nxt;
    j_r        <= j_nxt;
    prev_r     <= prev_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cyc_r      <= cyc_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_prob_r <= out_prob_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

endmodule

[rtl/ppv_checker.sv]
module ppv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [ppv_pkg::SAMPLE_W-1:0] in_lineages,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ppv_pkg::CNT_W-1:0]    out_mutant_count,
  input logic [ppv_pkg::PROB_W-1:0]   out_probability,
  input logic                         out_last,
  input logic                         out_bad_request
);
  import ppv_pkg::*;

  // A stalled request word holds until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_lineages))
    else $error("request word changed under stall");

  // A waiting word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probability) &&
    $stable(out_mutant_count) && $stable(out_last) && $stable(out_bad_request))
    else $error("output word changed under stall");

  // An error word is a lone, closing, all-zero word.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_request |-> out_last && out_mutant_count == '0 &&
    out_probability == '0)
    else $error("malformed error word");

  // Good words count mutants from one.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_request |-> out_mutant_count != '0)
    else $error("zero mutant count on good word");

  // A probability never exceeds 1.0.
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probability <= ONE_FIX)
    else $error("probability above one");

endmodule

bind polya_probability_vector_unit ppv_checker u_ppv_checker (.*);

[tb/sv/polya_probability_vector_unit_test.sv]
module polya_probability_vector_unit_test;
  import ppv_pkg::*;

  // One expected output word.
  typedef struct packed {
    logic [CNT_W-1:0]  mutant_count;
    logic [PROB_W-1:0] probability;
    logic              last;
    logic              bad_request;
  } dist_word_t;

  // Scoreboard: predicts the distribution words a request produces and checks
  // every word that leaves the block against the oldest prediction.
  class dist_scoreboard;
    int unsigned n_genes;
    logic [PROB_W-1:0] urn[MAX_SAMPLE_DEF];
    dist_word_t pending[$];
    int errors;

    function new();
      n_genes = 2;
      errors = 0;
    endfunction

    function void note_request(logic [SAMPLE_W-1:0] k_lin);
      int unsigned k, nn, j;
      logic [63:0] den, prev, cur, num, q;
      dist_word_t w;
      k = k_lin;
      if (n_genes < 2 || n_genes > MAX_SAMPLE_DEF || k < 2 || k > n_genes) begin
        w.mutant_count = '0;
        w.probability = '0;
        w.last = 1'b1;
        w.bad_request = 1'b1;
        pending.push_back(w);
        return;
      end
      foreach (urn[i]) urn[i] = '0;
      urn[0] = ONE_FIX;
      // Grow the sample one gene at a time, updating the vector in place.
      for (nn = k + 1; nn <= n_genes; nn++) begin
        den = 64'(nn - 1);
        prev = 0;
        for (j = 0; j <= nn - k && j < MAX_SAMPLE_DEF; j++) begin
          cur = 64'(urn[j]);
          num = prev * 64'(j) + cur * 64'(nn - 2 - j);
          q = (num + (den >> 1)) / den;
          if (q > 64'(ONE_FIX)) q = 64'(ONE_FIX);
          urn[j] = q[PROB_W-1:0];
          prev = cur;
        end
      end
      for (j = 0; j + 1 < n_genes; j++) begin
        w.mutant_count = CNT_W'(j + 1);
        w.probability = urn[j];
        w.last = (j + 2 == n_genes);
        w.bad_request = 1'b0;
        pending.push_back(w);
      end
    endfunction

    function void check_word(dist_word_t got);
      dist_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.mutant_count !== want.mutant_count) begin
        $display("%0t: mutant_count expected %0d actual %0d", $time,
                 want.mutant_count, got.mutant_count);
        errors++;
      end
      if (got.probability !== want.probability) begin
        $display("%0t: probability expected %h actual %h", $time,
                 want.probability, got.probability);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.bad_request !== want.bad_request) begin
        $display("%0t: bad_request expected %b actual %b", $time,
                 want.bad_request, got.bad_request);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_lineages = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_mutant_count;
  logic [PROB_W-1:0] out_probability;
  logic out_last;
  logic out_bad_request;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SAMPLE_W-1:0] cfg_sample_size = '0;

  dist_scoreboard board = new();
  longint unsigned cycle_count = 0;
  // A generous ceiling on the total run, allowing for the slowest requests and
  // for the extra time that output stalls add to emitting words.
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  polya_probability_vector_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_lineages(in_lineages),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mutant_count(out_mutant_count), .out_probability(out_probability),
    .out_last(out_last), .out_bad_request(out_bad_request),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_sample_size(cfg_sample_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[polya_probability_vector_unit] ERROR");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own: it switches between quiet
  // stretches and phases of light or heavy random stalling.
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Every word accepted on the output is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word({out_mutant_count, out_probability, out_last, out_bad_request});
  end

  int unsigned gap_left = 0;

  // Send one request word; a random gap may precede it, so the sender works in
  // bursts. Valid stays high across back-to-back words within a burst.
  task automatic send_request(input logic [SAMPLE_W-1:0] k_lin);
    if (gap_left == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lineages <= k_lin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(k_lin);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    in_lineages <= SAMPLE_W'($urandom_range(0, 127));
  endtask

  // Configuration is written only once the block has drained; error requests
  // finish quickly, so a short pause covers any word still in flight.
  task automatic drain();
    end_burst();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_sample_size(input int unsigned n);
    drain();
    cfg_valid <= 1'b1;
    cfg_sample_size <= SAMPLE_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.n_genes = n;
  endtask

  // Lineage counts favor the valid range, with some out-of-range noise.
  function automatic logic [SAMPLE_W-1:0] pick_lineages(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return SAMPLE_W'($urandom_range(0, 1));
    if (r == 1) return SAMPLE_W'($urandom_range(0, 127));
    if (r < 5) return SAMPLE_W'($urandom_range(n > 6 ? n - 4 : 2, n));
    return SAMPLE_W'($urandom_range(2, n));
  endfunction

  initial begin
    int unsigned n;
    int unsigned sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset sample size of two, bad counts on both sides, full lineages.
    send_request(2);
    send_request(0);
    send_request(1);
    send_request(3);
    send_request(7'h7F);
    set_sample_size(64);
    send_request(64);
    send_request(2);
    send_request(65);
    send_request(63);
    send_request(33);
    set_sample_size(3);
    send_request(2);
    send_request(3);
    send_request(4);
    // Out-of-range sample sizes make every request an error.
    set_sample_size(0);
    send_request(2);
    set_sample_size(1);
    send_request(0);
    set_sample_size(100);
    send_request(50);
    set_sample_size(127);
    send_request(64);
    set_sample_size(65);
    send_request(65);

    // Random phases: mostly small samples, some larger or out of range, a few at 64.
    sent = 0;
    while (sent < 270) begin
      case ($urandom_range(0, 9))
        0: n = 64;
        1: n = $urandom_range(0, 127);
        2, 3: n = $urandom_range(17, 63);
        default: n = $urandom_range(2, 16);
      endcase
      set_sample_size(n);
      gap_left = 0;
      repeat ((n > 32) ? $urandom_range(2, 6) : $urandom_range(8, 24)) begin
        gap_left = $urandom_range(0, 1);
        send_request(pick_lineages((n >= 2 && n <= 64) ? n : 64));
        sent++;
      end
    end

    end_burst();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("[polya_probability_vector_unit] OK");
    end else begin
      $display("[polya_probability_vector_unit] ERROR");
    end
    $finish;
  end

endmodule
